@@ rtl/core/cmfd_pkg.sv @@
package cmfd_pkg;

  localparam int ID_W     = 11;
  localparam int CAL_W    = 6;
  localparam int PERIOD_W = 16;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 16;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_TUSER_W = 4;

  // Register indexes on the configuration port.
  localparam logic [CIDX_W-1:0] REG_CHASSIS_LEFT  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_CHASSIS_RIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_GIMBAL_LEFT   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_GIMBAL_RIGHT  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_CALIB_COUNT   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_LED_PERIOD    = 3'd5;

  // Chassis opcodes in payload byte 0.
  localparam logic [7:0] OP_GAINS  = 8'h30;
  localparam logic [7:0] OP_STATUS = 8'hA1;

  // Result frame kinds.
  localparam logic [2:0] KIND_IGNORED   = 3'd0;
  localparam logic [2:0] KIND_ALIVE     = 3'd1;
  localparam logic [2:0] KIND_GAINS     = 3'd2;
  localparam logic [2:0] KIND_STATUS    = 3'd3;
  localparam logic [2:0] KIND_CALIBRATE = 3'd4;
  localparam logic [2:0] KIND_MEASURE   = 3'd5;

  localparam logic [5:0]  CALIB_MAX = 6'd63;
  localparam logic signed [16:0] HALF_TURN_POS = 17'sd4096;
  localparam logic signed [16:0] HALF_TURN_NEG = -17'sd4096;

  typedef struct packed {
    logic [ID_W-1:0]     chassis_left_id;
    logic [ID_W-1:0]     chassis_right_id;
    logic [ID_W-1:0]     gimbal_left_id;
    logic [ID_W-1:0]     gimbal_right_id;
    logic [CAL_W-1:0]    calibrate_count;
    logic [PERIOD_W-1:0] led_period;
  } cmfd_cfg_t;

  // Classified frame as it travels from the front end to the back end.
  // A gimbal frame carries KIND_CALIBRATE; the back end decides whether it
  // still calibrates or already measures.
  typedef struct packed {
    logic [2:0]  kind;
    logic        side;
    logic        led;
    logic [63:0] payload;
  } cmfd_item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } cmfd_qstat_t;

endpackage

@@ rtl/core/cmfd_cfg.sv @@
module cmfd_cfg
  import cmfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CIDX_W-1:0]    wr_index,
  input  logic [CDATA_W-1:0]   wr_data,
  output cmfd_cfg_t            cfg
);

  cmfd_cfg_t cfg_r;
  cmfd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_CHASSIS_LEFT:  cfg_nxt.chassis_left_id  = wr_data[ID_W-1:0];
        REG_CHASSIS_RIGHT: cfg_nxt.chassis_right_id = wr_data[ID_W-1:0];
        REG_GIMBAL_LEFT:   cfg_nxt.gimbal_left_id   = wr_data[ID_W-1:0];
        REG_GIMBAL_RIGHT:  cfg_nxt.gimbal_right_id  = wr_data[ID_W-1:0];
        REG_CALIB_COUNT:   cfg_nxt.calibrate_count  = wr_data[CAL_W-1:0];
        REG_LED_PERIOD:    cfg_nxt.led_period       = wr_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chassis_left_id  <= 11'd321;
      cfg_r.chassis_right_id <= 11'd322;
      cfg_r.gimbal_left_id   <= 11'd517;
      cfg_r.gimbal_right_id  <= 11'd518;
      cfg_r.calibrate_count  <= 6'd50;
      cfg_r.led_period       <= 16'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/cmfd_front.sv @@
module cmfd_front
  import cmfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmfd_cfg_t        cfg,
  input  logic             accept,
  input  logic             bus_select,
  input  logic [ID_W-1:0]  std_id,
  input  logic [63:0]      payload,
  output cmfd_item_t       item
);

  logic [15:0] frame_cnt_r;
  logic [15:0] frame_cnt_nxt;
  logic [15:0] cnt_inc;
  logic        led;
  logic        hit_cl, hit_cr, hit_gl, hit_gr;
  logic [7:0]  opcode;

  // The frame counter only moves on bus one, but the period compare runs
  // for every frame.
  always_comb begin
    cnt_inc       = bus_select ? frame_cnt_r : frame_cnt_r + 16'd1;
    led           = (cnt_inc == cfg.led_period);
    frame_cnt_nxt = led ? 16'd0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= 16'd0;
    end else if (accept) begin
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  assign hit_cl = (std_id == cfg.chassis_left_id);
  assign hit_cr = (std_id == cfg.chassis_right_id);
  assign hit_gl = (std_id == cfg.gimbal_left_id);
  assign hit_gr = (std_id == cfg.gimbal_right_id);
  assign opcode = payload[63:56];

  // First match in register order wins.
  always_comb begin
    item.kind    = KIND_IGNORED;
    item.side    = 1'b0;
    item.led     = led;
    item.payload = payload;
    if (!bus_select) begin
      if (hit_cl || hit_cr) begin
        item.side = !hit_cl;
        if (opcode == OP_GAINS) begin
          item.kind = KIND_GAINS;
        end else if (opcode == OP_STATUS) begin
          item.kind = KIND_STATUS;
        end else begin
          item.kind = KIND_ALIVE;
        end
      end else if (hit_gl || hit_gr) begin
        item.side = !hit_gl;
        item.kind = KIND_CALIBRATE;
      end
    end
  end

endmodule

@@ rtl/core/cmfd_queue.sv @@
module cmfd_queue
  import cmfd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cmfd_item_t  push_item,
  input  logic        pop,
  output cmfd_item_t  head,
  output cmfd_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  cmfd_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head           = mem_r[rd_ptr_r];
  assign stat.not_empty = (cnt_r != '0);
  assign stat.full      = (cnt_r == FULL);

endmodule

@@ rtl/core/cmfd_back.sv @@
module cmfd_back
  import cmfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmfd_cfg_t              cfg,
  input  logic                   item_valid,
  input  cmfd_item_t             item,
  output logic                   item_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TUSER_W-1:0] out_user,
  output logic [OUT_TDATA_W-1:0] out_data
);

  logic [5:0]  calib_cnt_r [2];
  logic [15:0] last_ang_r  [2];
  logic [15:0] offset_r    [2];
  logic [31:0] turns_r     [2];

  logic        out_valid_r;
  logic [2:0]  kind_r, kind_nxt;
  logic        side_r, led_r;
  logic [15:0] ang_r, ang_nxt;
  logic [15:0] spd_r, spd_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [7:0]  aux_r, aux_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic [47:0] gains_r, gains_nxt;

  logic        advance;
  logic        gimbal;
  logic        calib;
  logic        s;
  logic [15:0] g_ang;
  logic signed [16:0] step;
  logic [31:0] turns_nxt;
  logic [5:0]  calib_cnt_nxt;
  logic [63:0] p;

  assign advance  = item_valid && (!out_valid_r || out_ready);
  assign item_pop = advance;

  assign p      = item.payload;
  assign s      = item.side;
  assign gimbal = (item.kind == KIND_CALIBRATE);
  assign g_ang  = p[63:48];
  assign calib  = (calib_cnt_r[s] <= cfg.calibrate_count);
  assign step   = $signed({1'b0, g_ang}) - $signed({1'b0, last_ang_r[s]});
  assign calib_cnt_nxt = (calib_cnt_r[s] < CALIB_MAX) ? calib_cnt_r[s] + 6'd1
                                                      : calib_cnt_r[s];

  always_comb begin
    turns_nxt = turns_r[s];
    if (step > HALF_TURN_POS) begin
      turns_nxt = turns_r[s] - 32'd1;
    end else if (step < HALF_TURN_NEG) begin
      turns_nxt = turns_r[s] + 32'd1;
    end
  end

  always_comb begin
    kind_nxt  = item.kind;
    ang_nxt   = '0;
    spd_nxt   = '0;
    cur_nxt   = '0;
    aux_nxt   = '0;
    tot_nxt   = '0;
    gains_nxt = '0;
    case (item.kind)
      KIND_GAINS: begin
        gains_nxt = p[47:0];
      end
      KIND_STATUS: begin
        aux_nxt = p[55:48];
        cur_nxt = {p[39:32], p[47:40]};
        spd_nxt = {p[23:16], p[31:24]};
        ang_nxt = {p[7:0],   p[15:8]};
      end
      KIND_CALIBRATE: begin
        ang_nxt = g_ang;
        if (!calib) begin
          kind_nxt = KIND_MEASURE;
          spd_nxt  = p[47:32];
          cur_nxt  = p[31:16];
          aux_nxt  = p[15:8];
          tot_nxt  = {turns_nxt[18:0], 13'd0} + {16'd0, g_ang} - {16'd0, offset_r[s]};
        end
      end
      default: ;
    endcase
  end

  // Per-motor unwrap state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_cnt_r[0] <= '0;
      calib_cnt_r[1] <= '0;
      last_ang_r[0]  <= '0;
      last_ang_r[1]  <= '0;
      offset_r[0]    <= '0;
      offset_r[1]    <= '0;
      turns_r[0]     <= '0;
      turns_r[1]     <= '0;
    end else if (advance && gimbal) begin
      calib_cnt_r[s] <= calib_cnt_nxt;
      last_ang_r[s]  <= g_ang;
      if (calib) begin
        offset_r[s] <= g_ang;
      end else begin
        turns_r[s] <= turns_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r  <= kind_nxt;
      side_r  <= item.side;
      led_r   <= item.led;
      ang_r   <= ang_nxt;
      spd_r   <= spd_nxt;
      cur_r   <= cur_nxt;
      aux_r   <= aux_nxt;
      tot_r   <= tot_nxt;
      gains_r <= gains_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_user  = {side_r, kind_r};
  assign out_data  = {7'd0, gains_r, tot_r, aux_r, cur_r, spd_r, ang_r, led_r};

endmodule

@@ rtl/core/can_motor_feedback_decoder_core.sv @@
// Decoder for motor feedback frames received over CAN. Each input item is one
// frame (bus select, 11-bit standard identifier, eight payload bytes) and gives
// exactly one result item: chassis frames report link-alive, PID gain bytes or
// little-endian status words; gimbal frames first capture the angle offset for
// calibrate_count+1 frames per motor, then report big-endian angle, speed, raw
// current and hall byte, with the angle unwrapped into a 32-bit multi-turn total.
// led_toggle rises every led_period bus-one frames. A front end matches the
// identifier and opcode and keeps the frame counter, a small queue follows, and
// a back end holds the per-motor unwrap state and the output register. One item
// is taken per clock cycle while the queue is not full; an accepted input passes
// through the queue and then the output register, and the queue lets the input
// take up to QUEUE_DEPTH more items while a result waits on the output.
// Identifier and period registers are written through the cfg_ port (always
// ready) and must only change while no frame is in flight.
module can_motor_feedback_decoder_core
  import cmfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input frames.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,   // [0] bus_select
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [10:0] std_id, [74:11] payload
  // Decoded results.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [2:0] frame_kind, [3] motor_side
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] led_toggle, [16:1] angle_value,
                                             // [32:17] speed_value,
                                             // [48:33] current_value,
                                             // [56:49] aux_byte,
                                             // [88:57] multi_turn_angle,
                                             // [136:89] gain_bytes
  // Register writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CIDX_W-1:0]      cfg_index,
  input  logic [CDATA_W-1:0]     cfg_data
);

  cmfd_cfg_t   cfg;
  cmfd_item_t  front_item;
  cmfd_item_t  q_head;
  cmfd_qstat_t q_stat;
  logic        in_accept;
  logic        q_pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;
  assign in_accept = in_tvalid && in_tready;

  cmfd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Identifier match, opcode classification and the LED frame counter.
  cmfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .accept     (in_accept),
    .bus_select (in_tuser),
    .std_id     (in_tdata[10:0]),
    .payload    (in_tdata[74:11]),
    .item       (front_item)
  );

  cmfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Field extraction, calibration and angle unwrap, then the output register.
  cmfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (q_stat.not_empty),
    .item       (q_head),
    .item_pop   (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_user   (out_tuser),
    .out_data   (out_tdata)
  );

  // An item accepted into an empty design passes the queue and the output register and then shows up as a result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !q_stat.not_empty && !out_tvalid |-> ##2 out_tvalid)
    else $error("accepted item did not reach the output");

  // Only a measuring gimbal result carries a multi-turn total.
  a_total_only_measure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] != KIND_MEASURE |-> out_tdata[88:57] == 32'd0)
    else $error("total angle set on a non-measure result");

  // Ignored frames always report the left side.
  a_ignored_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == KIND_IGNORED |-> !out_tuser[3])
    else $error("ignored frame with nonzero motor side");

endmodule

@@ test/tb_can_motor_feedback_decoder_core.sv @@
module tb_can_motor_feedback_decoder_core;
  import cmfd_pkg::*;

  // Register indexes beyond the last register; writes to them must be dropped.
  localparam logic [CIDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CIDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 135;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int FULL_TURN    = 8192;

  // One decoded feedback item, field by field.
  typedef struct packed {
    logic [2:0]  kind;
    logic        side;
    logic        led;
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] current;
    logic [7:0]  aux;
    logic [31:0] total;
    logic [47:0] gains;
  } feedback_t;

  // Tracks the decoder state and compares every result item against the
  // oldest feedback item still waiting.
  class motor_feedback_scoreboard;
    cmfd_cfg_t   regs;
    logic [15:0] frame_cnt;
    logic [5:0]  calib_cnt [2];
    logic [15:0] last_ang [2];
    logic [15:0] offset_ang [2];
    logic [31:0] turns [2];
    feedback_t   expected_feedback [$];
    int          errors;

    function new();
      regs.chassis_left_id  = 11'd321;
      regs.chassis_right_id = 11'd322;
      regs.gimbal_left_id   = 11'd517;
      regs.gimbal_right_id  = 11'd518;
      regs.calibrate_count  = 6'd50;
      regs.led_period       = 16'd500;
      frame_cnt = '0;
      errors = 0;
      for (int i = 0; i < 2; i++) begin
        calib_cnt[i] = '0;
        last_ang[i] = '0;
        offset_ang[i] = '0;
        turns[i] = '0;
      end
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      case (idx)
        REG_CHASSIS_LEFT:  regs.chassis_left_id  = data[ID_W-1:0];
        REG_CHASSIS_RIGHT: regs.chassis_right_id = data[ID_W-1:0];
        REG_GIMBAL_LEFT:   regs.gimbal_left_id   = data[ID_W-1:0];
        REG_GIMBAL_RIGHT:  regs.gimbal_right_id  = data[ID_W-1:0];
        REG_CALIB_COUNT:   regs.calibrate_count  = data[CAL_W-1:0];
        REG_LED_PERIOD:    regs.led_period       = data[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_frame(logic bus, logic [ID_W-1:0] id, logic [63:0] pl);
      feedback_t r;
      int        s;
      int        delta;
      logic      calib;
      logic [15:0] a;
      r = '0;
      if (!bus) begin
        frame_cnt = frame_cnt + 16'd1;
        if (id == regs.chassis_left_id || id == regs.chassis_right_id) begin
          r.side = (id == regs.chassis_left_id) ? 1'b0 : 1'b1;
          r.kind = KIND_ALIVE;
          if (pl[63:56] == OP_GAINS) begin
            r.kind  = KIND_GAINS;
            r.gains = pl[47:0];
          end else if (pl[63:56] == OP_STATUS) begin
            // Status words are little-endian: low byte first in the payload.
            r.kind    = KIND_STATUS;
            r.aux     = pl[55:48];
            r.current = {pl[39:32], pl[47:40]};
            r.speed   = {pl[23:16], pl[31:24]};
            r.angle   = {pl[7:0], pl[15:8]};
          end
        end else if (id == regs.gimbal_left_id || id == regs.gimbal_right_id) begin
          s = (id == regs.gimbal_left_id) ? 0 : 1;
          a = pl[63:48];
          calib = calib_cnt[s] <= regs.calibrate_count;
          if (calib_cnt[s] < CALIB_MAX) calib_cnt[s] = calib_cnt[s] + 6'd1;
          r.side  = s[0];
          r.angle = a;
          if (calib) begin
            r.kind = KIND_CALIBRATE;
            last_ang[s] = a;
            offset_ang[s] = a;
          end else begin
            delta = int'(a) - int'(last_ang[s]);
            r.kind    = KIND_MEASURE;
            last_ang[s] = a;
            r.speed   = pl[47:32];
            r.current = pl[31:16];
            r.aux     = pl[15:8];
            if (delta > HALF_TURN_POS) turns[s] = turns[s] - 32'd1;
            else if (delta < HALF_TURN_NEG) turns[s] = turns[s] + 32'd1;
            r.total = turns[s] * FULL_TURN + {16'd0, a} - {16'd0, offset_ang[s]};
          end
        end
      end
      // The period compare runs for every frame, bus two included.
      if (frame_cnt == regs.led_period) begin
        frame_cnt = '0;
        r.led = 1'b1;
      end
      expected_feedback.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TUSER_W-1:0] tuser, logic [OUT_TDATA_W-1:0] tdata);
      feedback_t want;
      if (expected_feedback.size() == 0) begin
        $display("%0t: result item with no frame waiting, actual tuser 0x%0h tdata 0x%0h",
                 $time, tuser, tdata);
        errors++;
        return;
      end
      want = expected_feedback.pop_front();
      cmp_field("frame_kind", want.kind, tuser[2:0]);
      cmp_field("motor_side", want.side, tuser[3]);
      cmp_field("led_toggle", want.led, tdata[0]);
      cmp_field("angle_value", want.angle, tdata[16:1]);
      cmp_field("speed_value", want.speed, tdata[32:17]);
      cmp_field("current_value", want.current, tdata[48:33]);
      cmp_field("aux_byte", want.aux, tdata[56:49]);
      cmp_field("multi_turn_angle", want.total, tdata[88:57]);
      cmp_field("gain_bytes", want.gains, tdata[136:89]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic                   in_tuser = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CIDX_W-1:0]      cfg_index = '0;
  logic [CDATA_W-1:0]     cfg_data = '0;

  // Idling switches for the two sides; both are turned off for the last phase.
  logic tx_gaps_on = 1'b1;
  logic rx_stalls_on = 1'b1;
  int   rx_hold = 0;
  int   cycle_cnt = 0;

  motor_feedback_scoreboard sb = new();

  can_motor_feedback_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Every handshake is observed here at the clock edge, where all inputs and
  // outputs still hold their values from before the edge. Results are checked
  // before the new frame is predicted; an accepted frame first passes the queue
  // and the output register, so the two can never be the same item anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.predict_frame(in_tuser, in_tdata[10:0], in_tdata[74:11]);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // Result side backpressure: random stall bursts.
  always @(posedge clk) begin
    if (!rx_stalls_on) begin
      out_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rx_hold = $urandom_range(1, 10) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog so that a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one frame and returns at the edge where it is accepted. Valid is
  // left high so that a following frame can go out back to back.
  task automatic send_frame(input logic bus, input logic [ID_W-1:0] id, input logic [63:0] pl);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= bus;
    in_tdata  <= {5'd0, pl, id};
    do @(posedge clk); while (!in_tready);
  endtask

  // A gimbal frame with the given angle; speed, current and hall are random.
  task automatic send_gimbal(input logic [ID_W-1:0] id, input logic [15:0] ang);
    logic [63:0] pl;
    pl = {$urandom, $urandom};
    pl[63:48] = ang;
    send_frame(1'b0, id, pl);
  endtask

  // Stops the sender and waits until every predicted item has come back,
  // then lets the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_feedback.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Fills the bits above a register's width with noise, which must be dropped.
  function automatic logic [15:0] with_high_noise(logic [15:0] v, int w);
    logic [15:0] r;
    r = 16'($urandom);
    return (r << w) | v;
  endfunction

  // Writes every register, plus one write to an unused index. The block must
  // be idle when this is called.
  task automatic apply_settings(input logic [ID_W-1:0] cl, input logic [ID_W-1:0] cr,
                                input logic [ID_W-1:0] gl, input logic [ID_W-1:0] gr,
                                input logic [5:0] cal, input logic [15:0] per);
    cfg_write(REG_CHASSIS_LEFT, with_high_noise({5'd0, cl}, ID_W));
    cfg_write(REG_CHASSIS_RIGHT, with_high_noise({5'd0, cr}, ID_W));
    cfg_write(REG_GIMBAL_LEFT, with_high_noise({5'd0, gl}, ID_W));
    cfg_write(REG_GIMBAL_RIGHT, with_high_noise({5'd0, gr}, ID_W));
    cfg_write(REG_CALIB_COUNT, with_high_noise({10'd0, cal}, CAL_W));
    cfg_write(REG_LED_PERIOD, per);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return ID_W'($urandom);
    endcase
  endfunction

  // Most frames hit a configured identifier. Gimbal angles are chosen so that
  // wraps in both directions and steps right at the half-turn bound are common.
  task automatic send_random_frame();
    logic [63:0]     pl;
    logic [ID_W-1:0] id;
    logic            bus;
    logic [15:0]     ang;
    int              pick;
    int              s;
    pl   = {$urandom, $urandom};
    bus  = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      bus = 1'b1;
      id  = $urandom_range(0, 1) ? sb.regs.gimbal_left_id : ID_W'($urandom);
    end else if (pick < 16) begin
      id = ID_W'($urandom);
    end else if (pick < 46) begin
      id = $urandom_range(0, 1) ? sb.regs.chassis_right_id : sb.regs.chassis_left_id;
      case ($urandom_range(0, 4))
        0, 1: pl[63:56] = OP_GAINS;
        2, 3: pl[63:56] = OP_STATUS;
        default: ;
      endcase
    end else begin
      s  = $urandom_range(0, 1);
      id = s ? sb.regs.gimbal_right_id : sb.regs.gimbal_left_id;
      case ($urandom_range(0, 5))
        0: ang = 16'($urandom);
        1: ang = $urandom_range(0, 1) ? sb.last_ang[s] + 16'd4096 : sb.last_ang[s] - 16'd4096;
        2: ang = $urandom_range(0, 1) ? sb.last_ang[s] + 16'd4097 : sb.last_ang[s] - 16'd4097;
        default: ang = 16'($urandom_range(0, FULL_TURN - 1));
      endcase
      pl[63:48] = ang;
    end
    send_frame(bus, id, pl);
  endtask

  initial begin
    logic [ID_W-1:0] cl, cr, gl, gr;
    logic [5:0]      cal;
    logic [15:0]     per;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with the reset settings: bus two, an unknown identifier,
    // all chassis opcodes at payload extremes, and the first calibrations.
    send_frame(1'b1, sb.regs.chassis_left_id, 64'h0);
    send_frame(1'b0, 11'h7FF, '1);
    send_frame(1'b0, sb.regs.chassis_left_id, {OP_GAINS, 56'hFF_FFFF_FFFF_FFFF});
    send_frame(1'b0, sb.regs.chassis_right_id, {OP_STATUS, 56'h12_3456_789A_BCDE});
    send_frame(1'b0, sb.regs.chassis_left_id, 64'h0);
    send_frame(1'b0, sb.regs.chassis_right_id, '1);
    send_gimbal(sb.regs.gimbal_left_id, 16'h1F40);
    send_gimbal(sb.regs.gimbal_right_id, 16'hFFFF);

    // With calibrate_count at zero both gimbals measure from now on. The
    // angle walk wraps forward and back and sits right on the half-turn bound.
    wait_idle();
    apply_settings(11'd0, 11'h7FF, 11'd100, 11'd101, 6'd0, sb.frame_cnt + 16'd3);
    send_gimbal(11'd100, 16'd8000);
    send_gimbal(11'd100, 16'd100);
    send_gimbal(11'd100, 16'd8000);
    send_gimbal(11'd100, 16'd3904);
    send_gimbal(11'd100, 16'd8001);
    send_gimbal(11'd100, 16'd3904);
    send_gimbal(11'd100, 16'hFFFF);
    send_gimbal(11'd101, 16'd0);
    send_frame(1'b0, 11'd0, {OP_GAINS, 56'h0});
    send_frame(1'b0, 11'h7FF, {OP_STATUS, 56'hFE_DCBA_9876_5432});
    send_frame(1'b1, 11'd100, '1);

    // Shared identifiers: the first register in order wins.
    wait_idle();
    apply_settings(11'd5, 11'd5, 11'd6, 11'd6, 6'd1, sb.frame_cnt + 16'd2);
    send_frame(1'b0, 11'd5, {OP_STATUS, 24'h0, $urandom});
    send_gimbal(11'd6, 16'h0800);
    send_gimbal(11'd5, 16'h0800);

    // Random phases, each with fresh settings. The LED period is mostly set
    // just ahead of the frame counter so that toggles keep happening.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      tx_gaps_on   <= (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_stalls_on <= (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      cl = pick_id();
      cr = pick_id();
      gl = pick_id();
      gr = pick_id();
      if ($urandom_range(0, 5) == 0) cr = cl;
      if ($urandom_range(0, 5) == 0) gl = cr;
      if ($urandom_range(0, 5) == 0) gr = gl;
      case (ph)
        0: cal = 6'd0;
        7: cal = 6'd62;
        8: cal = 6'd63;
        default: cal = 6'($urandom_range(0, 4));
      endcase
      case (ph)
        3: per = 16'd1;
        7: per = 16'd0;
        8: per = 16'hFFFF;
        default: per = sb.frame_cnt + 16'($urandom_range(1, 30));
      endcase
      apply_settings(cl, cr, gl, gr, cal, per);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_frame();
        // Once in the run the sender holds off until everything has drained.
        if (ph == 4 && n == PHASE_ITEMS / 2) wait_idle();
      end
      // Leave the frame counter at zero so that a period of one toggles on
      // every bus-one frame in the phase that follows.
      if (ph == 2) begin
        wait_idle();
        while (sb.frame_cnt != 0) begin
          send_random_frame();
          wait_idle();
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
